// ===== rtl/core/rrs_pkg.sv =====
package rrs_pkg;

  // Fixed field widths of the ports.
  localparam int TIME_W     = 21;
  localparam int TBL_W      = 16;
  localparam int PIDX_W     = 4;
  localparam int QUANT_W    = 8;
  localparam int PCNT_W     = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // Register values after reset.
  localparam logic [QUANT_W-1:0] QUANTUM_RESET = 8'd5;
  localparam logic [PCNT_W-1:0]  PCOUNT_RESET  = 5'd16;

  // Input word action codes.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUANTUM = 1'b0,
    CFG_PCOUNT  = 1'b1
  } cfg_reg_t;

  // What a table scan looks for.
  typedef enum logic [1:0] {
    SCAN_LOWEST,
    SCAN_MATCH,
    SCAN_WINDOW
  } scan_mode_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CHECK,
    ST_SCAN_MIN,
    ST_CATCHUP,
    ST_SCAN_EQ,
    ST_DECIDE,
    ST_FETCH,
    ST_SLICE,
    ST_SCAN_WIN,
    ST_FINISH
  } rrs_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       take_item;
    logic       do_load;
    logic       emit_load;
    logic       scan_init;
    logic       scan_run;
    scan_mode_t scan_mode;
    logic       time_catchup;
    logic       pop_issue;
    logic       fetch_issue;
    logic       slice_latch;
    logic       finish;
    logic       emit_done;
  } rrs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_fill;
    logic scan_end;
    logic found;
    logic nothing_to_run;
    logic slot_free;
  } rrs_status_t;

endpackage

// ===== rtl/core/rrs_in_if.sv =====
interface rrs_in_if import rrs_pkg::*; ();

  logic              valid;
  logic              ready;
  logic              action;
  logic [PIDX_W-1:0] proc_index;
  logic [TBL_W-1:0]  arrival_time;
  logic [TBL_W-1:0]  burst_time;

  modport source (
    output valid, action, proc_index, arrival_time, burst_time,
    input  ready
  );

  modport sink (
    input  valid, action, proc_index, arrival_time, burst_time,
    output ready
  );

endinterface

// ===== rtl/core/rrs_out_if.sv =====
interface rrs_out_if import rrs_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [TIME_W-1:0]  start_time;
  logic [PIDX_W-1:0]  dispatched;
  logic [QUANT_W-1:0] run_length;
  logic               completed;
  logic [TIME_W-1:0]  turnaround;
  logic [TIME_W-1:0]  waiting;
  logic               all_done;

  modport source (
    output valid, start_time, dispatched, run_length, completed, turnaround,
           waiting, all_done,
    input  ready
  );

  modport sink (
    input  valid, start_time, dispatched, run_length, completed, turnaround,
           waiting, all_done,
    output ready
  );

endinterface

// ===== rtl/core/rrs_ctrl.sv =====
module rrs_ctrl import rrs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_action,
  output logic        in_ready,
  input  rrs_status_t status,
  output rrs_cmd_t    cmd
);

  rrs_state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (in_action == ACT_LOAD) ? ST_LOAD : ST_CHECK;
        end
      end
      ST_LOAD: begin
        if (status.slot_free) state_next = ST_IDLE;
      end
      ST_CHECK: begin
        state_next = status.need_fill ? ST_SCAN_MIN : ST_DECIDE;
      end
      ST_SCAN_MIN: begin
        if (status.scan_end) state_next = ST_CATCHUP;
      end
      ST_CATCHUP: begin
        state_next = status.found ? ST_SCAN_EQ : ST_DECIDE;
      end
      ST_SCAN_EQ: begin
        if (status.scan_end) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!status.nothing_to_run) begin
          state_next = ST_FETCH;
        end else if (status.slot_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_FETCH:    state_next = ST_SLICE;
      ST_SLICE:    state_next = ST_SCAN_WIN;
      ST_SCAN_WIN: begin
        if (status.scan_end) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.slot_free) state_next = ST_IDLE;
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  // Commands for the current state.
  always_comb begin
    cmd       = '0;
    cmd.scan_mode = SCAN_LOWEST;
    in_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.take_item = in_valid;
      end
      ST_LOAD: begin
        cmd.do_load   = status.slot_free;
        cmd.emit_load = status.slot_free;
      end
      ST_CHECK: begin
        cmd.scan_init = status.need_fill;
      end
      ST_SCAN_MIN: begin
        cmd.scan_run  = 1'b1;
        cmd.scan_mode = SCAN_LOWEST;
      end
      ST_CATCHUP: begin
        cmd.time_catchup = status.found;
        cmd.scan_init    = status.found;
      end
      ST_SCAN_EQ: begin
        cmd.scan_run  = 1'b1;
        cmd.scan_mode = SCAN_MATCH;
      end
      ST_DECIDE: begin
        cmd.pop_issue = !status.nothing_to_run;
        cmd.emit_done = status.nothing_to_run && status.slot_free;
      end
      ST_FETCH: begin
        cmd.fetch_issue = 1'b1;
      end
      ST_SLICE: begin
        cmd.slice_latch = 1'b1;
        cmd.scan_init   = 1'b1;
      end
      ST_SCAN_WIN: begin
        cmd.scan_run  = 1'b1;
        cmd.scan_mode = SCAN_WINDOW;
      end
      ST_FINISH: begin
        cmd.finish = status.slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/core/rrs_datapath.sv =====
module rrs_datapath import rrs_pkg::*; #(
  parameter int MAX_PROCESSES = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [PIDX_W-1:0]     in_proc_index,
  input  logic [TBL_W-1:0]      in_arrival_time,
  input  logic [TBL_W-1:0]      in_burst_time,
  input  rrs_cmd_t              cmd,
  output rrs_status_t           status,
  rrs_out_if.source             result
);

  localparam int IW = $clog2(MAX_PROCESSES);
  localparam int NW = $clog2(MAX_PROCESSES + 1);
  localparam int CW = (NW > PCNT_W) ? NW : PCNT_W;
  localparam logic [NW-1:0] MAX_N    = NW'(MAX_PROCESSES);
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_PROCESSES - 1);

  // Configuration registers.
  logic [QUANT_W-1:0] quantum;
  logic [PCNT_W-1:0]  pcount;

  // Captured load word.
  logic [PIDX_W-1:0] ld_idx;
  logic [TBL_W-1:0]  ld_arr;
  logic [TBL_W-1:0]  ld_burst;

  // Process tables and the ready queue.
  logic [TBL_W-1:0] arr_mem   [MAX_PROCESSES];
  logic [TBL_W-1:0] burst_mem [MAX_PROCESSES];
  logic [TBL_W-1:0] rem_mem   [MAX_PROCESSES];
  logic [IW-1:0]    fifo_mem  [MAX_PROCESSES];

  // Run state.
  logic [MAX_PROCESSES-1:0] rem_written;
  logic [MAX_PROCESSES-1:0] enq_mask;
  logic [IW-1:0]            head;
  logic [IW-1:0]            tail;
  logic [NW-1:0]            fill;
  logic [NW-1:0]            fin;
  logic [TIME_W-1:0]        cur_time;

  // Scan state.
  logic [NW-1:0]    cnt;
  logic             found;
  logic [TBL_W-1:0] earliest;

  // Registered read data.
  logic [TBL_W-1:0] arr_rd;
  logic [TBL_W-1:0] burst_rd;
  logic [TBL_W-1:0] rem_rd;
  logic             written_rd;
  logic [IW-1:0]    rd_idx;
  logic [IW-1:0]    fifo_rd;

  // The process being dispatched.
  logic [IW-1:0]      p_idx;
  logic [TBL_W-1:0]   p_rem;
  logic [TBL_W-1:0]   p_arr;
  logic [TBL_W-1:0]   p_burst;
  logic [QUANT_W-1:0] p_slice;
  logic [TIME_W-1:0]  p_start;
  logic [TIME_W:0]    p_end;

  // Output register.
  logic               out_valid;
  logic [TIME_W-1:0]  out_start;
  logic [PIDX_W-1:0]  out_disp;
  logic [QUANT_W-1:0] out_run;
  logic               out_completed;
  logic [TIME_W-1:0]  out_tat;
  logic [TIME_W-1:0]  out_wait;
  logic               out_all_done;

  // Combinational helpers.
  logic [CW-1:0]      pcount_ext;
  logic [NW-1:0]      n_active;
  logic [QUANT_W-1:0] q_eff;
  logic [IW-1:0]      rd_addr;
  logic [TBL_W-1:0]   eff_rem;
  logic [QUANT_W-1:0] slice_val;
  logic               ld_in_range;
  logic               scan_proc;
  logic               eligible;
  logic               window_hit;
  logic               scan_push;
  logic               requeue;
  logic               push_en;
  logic [IW-1:0]      push_idx;
  logic [IW-1:0]      head_inc;
  logic [IW-1:0]      tail_inc;
  logic [TIME_W-1:0]  tat;
  logic               slot_free;

  // Active process count and effective quantum.
  assign pcount_ext = CW'(pcount);
  assign n_active   = (pcount_ext > CW'(MAX_PROCESSES)) ? MAX_N : NW'(pcount_ext);
  assign q_eff      = (quantum == '0) ? QUANT_W'(1) : quantum;

  // Table read address: scan counter, or the popped process.
  assign rd_addr   = cmd.fetch_issue ? fifo_rd : cnt[IW-1:0];
  assign eff_rem   = written_rd ? rem_rd : burst_rd;
  assign slice_val = (eff_rem < TBL_W'(q_eff)) ? eff_rem[QUANT_W-1:0] : q_eff;
  assign ld_in_range = (32'(ld_idx) < 32'(MAX_PROCESSES));

  // Scan evaluation: the data read last cycle belongs to rd_idx.
  assign scan_proc  = cmd.scan_run && (cnt != '0);
  assign eligible   = !enq_mask[rd_idx];
  assign window_hit = (TIME_W'(arr_rd) > p_start) && ((TIME_W + 1)'(arr_rd) <= p_end);
  always_comb begin
    scan_push = 1'b0;
    unique case (cmd.scan_mode)
      SCAN_MATCH:  scan_push = scan_proc && eligible && (arr_rd == earliest);
      SCAN_WINDOW: scan_push = scan_proc && eligible && window_hit;
      default:     scan_push = 1'b0;
    endcase
  end

  // Queue push from a scan hit or a preempted process.
  assign requeue  = cmd.finish && (p_rem > TBL_W'(p_slice));
  assign push_en  = (scan_push || requeue) && (fill < MAX_N);
  assign push_idx = requeue ? p_idx : rd_idx;
  assign head_inc = (head == LAST_IDX) ? '0 : head + 1'b1;
  assign tail_inc = (tail == LAST_IDX) ? '0 : tail + 1'b1;

  assign tat       = p_end[TIME_W-1:0] - TIME_W'(p_arr);
  assign slot_free = !out_valid || result.ready;

  // Status to the controller.
  assign status.need_fill      = (fill == '0) && (fin < n_active);
  assign status.scan_end       = (cnt == n_active);
  assign status.found          = found;
  assign status.nothing_to_run = (fin >= n_active) || (fill == '0);
  assign status.slot_free      = slot_free;

  // Memories: table writes, queue writes and registered reads.
  always_ff @(posedge clk) begin
    if (cmd.do_load && ld_in_range) begin
      arr_mem[IW'(ld_idx)]   <= ld_arr;
      burst_mem[IW'(ld_idx)] <= ld_burst;
    end
    if (cmd.finish) begin
      rem_mem[p_idx] <= requeue ? (p_rem - TBL_W'(p_slice)) : '0;
    end
    if (push_en) begin
      fifo_mem[tail] <= push_idx;
    end
    arr_rd   <= arr_mem[rd_addr];
    burst_rd <= burst_mem[rd_addr];
    rem_rd   <= rem_mem[rd_addr];
    if (cmd.pop_issue) begin
      fifo_rd <= fifo_mem[head];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum     <= QUANTUM_RESET;
      pcount      <= PCOUNT_RESET;
      rem_written <= '0;
      enq_mask    <= '0;
      head        <= '0;
      tail        <= '0;
      fill        <= '0;
      fin         <= '0;
      cur_time    <= '0;
      cnt         <= '0;
      found       <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_QUANTUM: quantum <= cfg_data[QUANT_W-1:0];
          CFG_PCOUNT:  pcount  <= cfg_data[PCNT_W-1:0];
          default:     quantum <= quantum;
        endcase
      end

      if (cmd.do_load) begin
        rem_written <= '0;
        enq_mask    <= '0;
        head        <= '0;
        tail        <= '0;
        fill        <= '0;
        fin         <= '0;
        cur_time    <= '0;
      end else begin
        // Scan counter and lowest-arrival search.
        if (cmd.scan_init) begin
          cnt   <= '0;
          found <= 1'b0;
        end else if (cmd.scan_run) begin
          if (cnt != n_active) cnt <= cnt + 1'b1;
          if (cmd.scan_mode == SCAN_LOWEST && scan_proc && eligible &&
              (!found || arr_rd < earliest)) begin
            found <= 1'b1;
          end
        end

        if (cmd.time_catchup && (TIME_W'(earliest) > cur_time)) begin
          cur_time <= TIME_W'(earliest);
        end

        // Queue pointers; a push and a pop never fall in one cycle.
        if (push_en) begin
          tail               <= tail_inc;
          fill               <= fill + 1'b1;
          enq_mask[push_idx] <= 1'b1;
        end else if (cmd.pop_issue) begin
          head <= head_inc;
          fill <= fill - 1'b1;
        end

        if (cmd.finish) begin
          cur_time           <= p_end[TIME_W-1:0];
          rem_written[p_idx] <= 1'b1;
          if (!requeue) fin <= fin + 1'b1;
        end
      end

      if (cmd.emit_load || cmd.emit_done || cmd.finish) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      ld_idx   <= in_proc_index;
      ld_arr   <= in_arrival_time;
      ld_burst <= in_burst_time;
    end

    rd_idx     <= rd_addr;
    written_rd <= rem_written[rd_addr];

    if (cmd.scan_run && cmd.scan_mode == SCAN_LOWEST && scan_proc && eligible &&
        (!found || arr_rd < earliest)) begin
      earliest <= arr_rd;
    end

    if (cmd.fetch_issue) begin
      p_idx <= fifo_rd;
    end

    if (cmd.slice_latch) begin
      p_rem   <= eff_rem;
      p_arr   <= arr_rd;
      p_burst <= burst_rd;
      p_slice <= slice_val;
      p_start <= cur_time;
      p_end   <= (TIME_W + 1)'(cur_time) + (TIME_W + 1)'(slice_val);
    end

    // Result word.
    if (cmd.emit_load) begin
      out_start     <= '0;
      out_disp      <= '0;
      out_run       <= '0;
      out_completed <= 1'b0;
      out_tat       <= '0;
      out_wait      <= '0;
      out_all_done  <= 1'b0;
    end else if (cmd.emit_done) begin
      out_start     <= cur_time;
      out_disp      <= '0;
      out_run       <= '0;
      out_completed <= 1'b0;
      out_tat       <= '0;
      out_wait      <= '0;
      out_all_done  <= 1'b1;
    end else if (cmd.finish) begin
      out_start     <= p_start;
      out_disp      <= PIDX_W'(p_idx);
      out_run       <= p_slice;
      out_completed <= !requeue;
      out_tat       <= requeue ? '0 : tat;
      out_wait      <= requeue ? '0 : (tat - TIME_W'(p_burst));
      out_all_done  <= 1'b0;
    end
  end

  assign result.valid      = out_valid;
  assign result.start_time = out_start;
  assign result.dispatched = out_disp;
  assign result.run_length = out_run;
  assign result.completed  = out_completed;
  assign result.turnaround = out_tat;
  assign result.waiting    = out_wait;
  assign result.all_done   = out_all_done;

endmodule

// ===== rtl/core/round_robin_cpu_scheduler_unit.sv =====
// Round-robin CPU scheduler with a fixed quantum over a table of up to
// MAX_PROCESSES processes. A load word writes one process's arrival and
// burst and restarts the schedule. A step word makes one dispatch and
// returns the slice start, the process, the run length and, on completion,
// turnaround and waiting time. A dispatching step walks the process table
// through a single registered read port, one entry per cycle, over
// n = process_count entries: once when the ready queue holds work, and,
// when the queue first has to be refilled from the next arrival time,
// before that to find the next arrival and to queue the processes that
// arrive then. The result sits in an output register, so the next word is
// taken while a result waits; a step finishes only once that register is
// free. Configuration may be written only while no word is in flight.
module round_robin_cpu_scheduler_unit import rrs_pkg::*; #(
  parameter int MAX_PROCESSES = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rrs_in_if.sink                sched_in,
  rrs_out_if.source             sched_out
);

  rrs_cmd_t    cmd;
  rrs_status_t status;
  logic        in_ready;

  // Sequencer.
  rrs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sched_in.valid),
    .in_action (sched_in.action),
    .in_ready  (in_ready),
    .status    (status),
    .cmd       (cmd)
  );

  assign sched_in.ready = in_ready;

  // Tables, ready queue, timing arithmetic and result register.
  rrs_datapath #(
    .MAX_PROCESSES (MAX_PROCESSES)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_proc_index   (sched_in.proc_index),
    .in_arrival_time (sched_in.arrival_time),
    .in_burst_time   (sched_in.burst_time),
    .cmd             (cmd),
    .status          (status),
    .result          (sched_out)
  );

endmodule
